// File: hw/rtl/ucb1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb1_pkg
// Shared types, constants and the log table for the UCB1 child selector.
// ----------------------------------------------------------------------------
package ucb1_pkg;

	localparam int CountBits   = 32;
	localparam int MaxChildren = 64;
	localparam int IdxBits     = 6;
	localparam int ScoreBits   = 19;
	localparam int PosBits     = $clog2(MaxChildren + 1);
	localparam int LnBits      = 23;
	localparam logic [ScoreBits-1:0] ScoreMax = 19'h7FFFF;
	localparam logic [15:0] Ln2Q16 = 16'd45426;
	localparam logic [0:0] RegAgentColor = 1'b0;

	typedef struct packed {
		logic [CountBits-1:0] parent_count;
		logic                 side_to_move;
		logic [CountBits-1:0] child_wins;
		logic [CountBits-1:0] child_plays;
		logic                 last_child;
	} in_item_t;

	typedef struct packed {
		logic [IdxBits-1:0]   best_index;
		logic [ScoreBits-1:0] top_score;
		logic                 zero_plays_error;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOG, ST_DIV, ST_SQRT, ST_DONE
	} state_t;

	typedef struct packed {
		logic                 start;
		logic                 busy;
		logic                 done;
		logic [ScoreBits-1:0] score;
	} score_ctl_t;

	function automatic logic [15:0] ln_frac(input logic [3:0] m);
		logic [15:0] r;
		case (m)
			4'd0:  r = 16'd0;
			4'd1:  r = 16'd3973;
			4'd2:  r = 16'd7719;
			4'd3:  r = 16'd11262;
			4'd4:  r = 16'd14624;
			4'd5:  r = 16'd17822;
			4'd6:  r = 16'd20870;
			4'd7:  r = 16'd23783;
			4'd8:  r = 16'd26573;
			4'd9:  r = 16'd29248;
			4'd10: r = 16'd31818;
			4'd11: r = 16'd34292;
			4'd12: r = 16'd36675;
			4'd13: r = 16'd38975;
			4'd14: r = 16'd41197;
			default: r = 16'd43347;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/ucb1_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb1_score
// Bit-serial scorer: log by leading-one scan, two restoring dividers sharing
// one sequencer, and a bit-pair square root.
// ----------------------------------------------------------------------------
module ucb1_score (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ucb1_pkg::CountBits-1:0] parent,
	input  logic [ucb1_pkg::CountBits-1:0] wins,
	input  logic [ucb1_pkg::CountBits-1:0] plays,
	output ucb1_pkg::score_ctl_t          ctl
);
	localparam int CB = ucb1_pkg::CountBits;
	localparam int LB = ucb1_pkg::LnBits;
	// ratio dividend wins<<16 is CB+16 bits, quotient kept to CB+16 bits
	localparam int NB = CB + 16;

	ucb1_pkg::state_t state_q, state_d;
	logic [5:0]      cnt_q;
	logic [CB-1:0]   scan_q;    // parent shifted left until MSB set
	logic [5:0]      lead_q;
	logic [CB-1:0]   d_q;       // divisor
	logic [NB-1:0]   rn_q;      // ratio dividend/quotient shifter
	logic [CB:0]     rr_q;      // ratio remainder
	logic [LB:0]     qn_q;      // q dividend/quotient shifter
	logic [CB:0]     qr_q;
	logic [LB+14:0]  sx_q;      // sqrt radicand shifter (q<<16), even width
	logic [LB+1:0]   sr_q;      // sqrt partial remainder
	logic [20:0]     sq_q;      // sqrt root

	logic [CB:0]   rr_t, qr_t;
	logic [LB+1:0] s_rem, s_try;
	logic [LB-1:0] ln_val;
	logic [3:0]    mbits;
	logic [NB:0]   sum;

	// mantissa bits below the leading one after normalization
	assign mbits  = scan_q[CB-2 -: 4];
	assign ln_val = LB'(lead_q) * LB'(ucb1_pkg::Ln2Q16) + LB'(ucb1_pkg::ln_frac(mbits));
	assign rr_t   = {rr_q[CB-1:0], rn_q[NB-1]};
	assign qr_t   = {qr_q[CB-1:0], qn_q[LB]};
	assign s_rem  = {sr_q[LB-1:0], sx_q[LB+14 -: 2]};
	assign s_try  = {sq_q, 2'b01};
	assign sum    = (NB+1)'(rn_q) + (NB+1)'(sq_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ucb1_pkg::ST_IDLE: if (start) state_d = ucb1_pkg::ST_LOG;
			ucb1_pkg::ST_LOG:  if (scan_q[CB-1] || cnt_q == 6'(CB)) state_d = ucb1_pkg::ST_DIV;
			ucb1_pkg::ST_DIV:  if (cnt_q == 6'(NB - 1) || cnt_q == 6'd63) state_d = ucb1_pkg::ST_DIV;
			ucb1_pkg::ST_SQRT: if (cnt_q == 6'd19) state_d = ucb1_pkg::ST_DONE;
			ucb1_pkg::ST_DONE: state_d = ucb1_pkg::ST_IDLE;
			default: state_d = ucb1_pkg::ST_IDLE;
		endcase
		if (state_q == ucb1_pkg::ST_DIV && cnt_q == 6'(NB - 1))
			state_d = ucb1_pkg::ST_SQRT;
	end

	// score is valid during the done cycle: quotient and root are settled
	always_comb begin
		ctl.start = start;
		ctl.busy  = (state_q != ucb1_pkg::ST_IDLE);
		ctl.done  = (state_q == ucb1_pkg::ST_DONE);
		if (sum > (NB+1)'(ucb1_pkg::ScoreMax)) ctl.score = ucb1_pkg::ScoreMax;
		else ctl.score = sum[ucb1_pkg::ScoreBits-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ucb1_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ucb1_pkg::ST_IDLE: if (start) begin
				scan_q <= parent;
				lead_q <= 6'(CB - 1);
				d_q    <= plays;
				rn_q   <= {wins, 16'd0};
				rr_q   <= '0;
				qr_q   <= '0;
			end
			ucb1_pkg::ST_LOG: begin
				// shift left one bit per cycle until the leading one is at the top
				if (!scan_q[CB-1] && cnt_q != 6'(CB)) begin
					scan_q <= {scan_q[CB-2:0], 1'b0};
					lead_q <= lead_q - 6'd1;
				end else begin
					// zero parent: log term zero
					qn_q <= (scan_q[CB-1]) ? {ln_val, 1'b0} : '0;
				end
			end
			ucb1_pkg::ST_DIV: begin
				// one quotient bit per cycle for both divisions
				if (rr_t >= {1'b0, d_q}) begin
					rr_q <= rr_t - {1'b0, d_q};
					rn_q <= {rn_q[NB-2:0], 1'b1};
				end else begin
					rr_q <= rr_t;
					rn_q <= {rn_q[NB-2:0], 1'b0};
				end
				if (cnt_q >= 6'(NB - LB - 1)) begin
					if (qr_t >= {1'b0, d_q}) begin
						qr_q <= qr_t - {1'b0, d_q};
						qn_q <= {qn_q[LB-1:0], 1'b1};
					end else begin
						qr_q <= qr_t;
						qn_q <= {qn_q[LB-1:0], 1'b0};
					end
				end
				if (cnt_q == 6'(NB - 1)) begin
					sr_q <= '0;
					sq_q <= '0;
				end
			end
			ucb1_pkg::ST_SQRT: begin
				if (cnt_q == 6'd0) begin
					// q is below 2^22, so its top quotient bits are always zero
					sx_q <= {qn_q[LB-2:0], 16'd0};
				end else begin
					// two radicand bits per cycle, one root bit
					if (s_rem >= s_try) begin
						sr_q <= s_rem - s_try;
						sq_q <= {sq_q[19:0], 1'b1};
					end else begin
						sr_q <= s_rem;
						sq_q <= {sq_q[19:0], 1'b0};
					end
					sx_q <= {sx_q[LB+12:0], 2'b00};
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |=> !ctl.done) else $error("done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == ucb1_pkg::ST_IDLE) |=> state_q == ucb1_pkg::ST_LOG)
		else $error("start lost");
	a_sqrt_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ucb1_pkg::ST_SQRT |-> cnt_q <= 6'd19) else $error("sqrt overrun");
`endif
endmodule

// File: hw/rtl/ucb1_child_selector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb1_child_selector_core
// UCB1 child selection over one run of child items, serial arithmetic.
// ----------------------------------------------------------------------------
// channel   | direction | handshake           | payload
// in        | input     | in_valid/in_stall   | ucb1_pkg::in_item_t
// out       | output    | out_valid/out_stall | ucb1_pkg::out_item_t
// cfg       | input     | APB psel/penable    | agent_color at address 0
//
// A scored child holds the input through the leading-one scan of the parent
// count (shortest with its top bit set, longest for a zero parent), 48 divider
// steps, the square-root steps, settling of the score and release of the input.
// Zero-play and excess children are accepted without holding the input.
// Reset clears all run state and agent_color.
// The next transfer is taken while a result waits in the output register,
// unless a new last child would need that register.
// ----------------------------------------------------------------------------
module ucb1_child_selector_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ucb1_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ucb1_pkg::out_item_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	localparam int PB = ucb1_pkg::PosBits;

	logic                 agent_q;
	logic [PB-1:0]        count_q;
	logic [ucb1_pkg::IdxBits-1:0]   best_idx_q;
	logic [ucb1_pkg::ScoreBits-1:0] top_score_q;
	logic                 have_q, err_q;
	logic                 busy_q, last_q;   // a child is being scored
	logic [PB-1:0]        pos_q;
	ucb1_pkg::score_ctl_t sc;
	logic                 accept, scored, finish_now, emit;
	logic                 take_score;
	logic [ucb1_pkg::CountBits-1:0] wins_adj;

	assign pready = 1'b1;
	assign prdata = {31'd0, agent_q};

	// hold input while scoring or while an old result blocks a new one
	assign in_stall = busy_q || (out_valid && out_stall && in_data.last_child);
	assign accept   = in_valid && !in_stall;
	assign scored   = accept && (count_q < PB'(ucb1_pkg::MaxChildren))
	                  && (in_data.child_plays != '0);
	// unscored last child finishes at once, scored one when the scorer is done
	assign finish_now = accept && in_data.last_child && !scored;
	assign take_score = sc.done;
	assign emit = finish_now || (take_score && last_q);

	// opponent view
	assign wins_adj = (in_data.side_to_move != agent_q)
	                  ? in_data.child_plays - in_data.child_wins : in_data.child_wins;

	ucb1_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scored),
		.parent (in_data.parent_count),
		.wins   (wins_adj),
		.plays  (in_data.child_plays),
		.ctl    (sc)
	);

	logic                 new_have;
	logic [ucb1_pkg::IdxBits-1:0]   new_idx;
	logic [ucb1_pkg::ScoreBits-1:0] new_score;
	always_comb begin
		new_have  = have_q;
		new_idx   = best_idx_q;
		new_score = top_score_q;
		if (take_score && (!have_q || sc.score > top_score_q)) begin
			new_have  = 1'b1;
			new_idx   = pos_q[ucb1_pkg::IdxBits-1:0];
			new_score = sc.score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agent_q      <= 1'b0;
			count_q      <= '0;
			best_idx_q   <= '0;
			top_score_q  <= '0;
			have_q       <= 1'b0;
			err_q        <= 1'b0;
			busy_q       <= 1'b0;
			last_q       <= 1'b0;
			pos_q        <= '0;
			out_valid    <= 1'b0;
			out_data     <= '0;
		end else begin
			if (psel && penable && pwrite && paddr == {ucb1_pkg::RegAgentColor, 1'b0})
				agent_q <= pwdata[0];
			if (out_valid && !out_stall) out_valid <= 1'b0;
			// excess children only advance nothing; zero-play sets error
			if (accept && count_q < PB'(ucb1_pkg::MaxChildren)) begin
				count_q <= count_q + PB'(1);
				if (in_data.child_plays == '0) err_q <= 1'b1;
			end
			if (scored) begin
				busy_q <= 1'b1;
				last_q <= in_data.last_child;
				pos_q  <= count_q;
			end
			if (take_score) begin
				busy_q       <= 1'b0;
				have_q       <= new_have;
				best_idx_q   <= new_idx;
				top_score_q  <= new_score;
			end
			if (emit) begin
				out_valid <= 1'b1;
				out_data.best_index <= new_have ? new_idx : '0;
				out_data.top_score <= new_have ? new_score : '0;
				out_data.zero_plays_error <= err_q ||
					(finish_now && count_q < PB'(ucb1_pkg::MaxChildren)
					 && in_data.child_plays == '0);
				count_q      <= '0;
				have_q       <= 1'b0;
				err_q        <= 1'b0;
				best_idx_q   <= '0;
				top_score_q  <= '0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !emit) else $error("result overwritten");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> in_stall) else $error("input taken while scoring");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sc.done |-> busy_q) else $error("stray score");
`endif
endmodule
